// ----- hw/rtl/soc_pkg.sv -----
// Shared types and constants for the span occlusion clipper.
package soc_pkg;

   localparam int ROW_W = 9;

   typedef enum logic [0:0] {
      REQ_COLUMN = 1'b0,
      REQ_PAINT  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [8:0] lo;
      logic [8:0] hi;
   } range_type;

   typedef struct packed {
      logic        req_type;
      logic signed [15:0] row_start;
      logic signed [15:0] row_end;
      logic signed [23:0] face_top_fixed;
      logic [15:0] v_step;
      logic [7:0]  plane_height;
      logic [15:0] depth_q8;
      logic [7:0]  material;
      logic [27:0] span_attributes;
      logic [7:0]  top_row_in;
   } req_type_type;

   typedef struct packed {
      logic        span_valid;
      logic [7:0]  span_row_start;
      logic [7:0]  span_row_end;
      logic [15:0] span_depth_q8;
      logic [7:0]  span_material;
      logic [27:0] span_attr_out;
      logic [15:0] span_v_step;
      logic [15:0] span_v_start;
      logic [7:0]  span_plane_height;
      logic        painted_any;
      logic [7:0]  top_row_out;
      logic        last;
   } rsp_type;

   localparam logic [15:0] WRAP16 = 16'hFFFF;

endpackage

// ----- hw/rtl/soc_if.sv -----
// Valid/ready channel interfaces for request and result items.
interface soc_req_if import soc_pkg::*; ();
   logic          valid;
   logic          ready;
   req_type_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface soc_rsp_if import soc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/soc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module soc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/soc_tex.sv -----
// Texture start: (row*256 - face_top) * v_step / 256, toward zero, wrapped to 16 bits.
module soc_tex import soc_pkg::*; (
   input  logic [8:0]         row,
   input  logic signed [23:0] face_top,
   input  logic [15:0]        v_step,
   output logic [15:0]        v_start
);
   logic signed [25:0] d;
   logic [25:0]        mag;
   logic [41:0]        prod;
   logic [15:0]        pq;

   always_comb begin
      d    = $signed({1'b0, row, 16'd0} >>> 8) - 26'(face_top);
      mag  = d[25] ? 26'(-d) : d;
      prod = 42'(mag) * 42'(v_step);
      pq   = prod[23:8];
      v_start = d[25] ? 16'(-pq) : pq;
   end
endmodule

// ----- hw/rtl/span_occlusion_clipper_core.sv -----
// Span occlusion clipper top level.
// A column start's result is registered and valid in the cycle after acceptance; a paint
// walks the range RAM through read, evaluate and output states, with a read and write
// state pair per entry shifted on a split or removal.
// Items are taken one at a time; a column start also rewrites the range RAM.
// Reset: synchronous; a sweep writes every entry of the range RAM
// (entry zero the whole column) before the first item is taken.
module span_occlusion_clipper_core import soc_pkg::*; #(
   parameter int COLUMN_ROWS = 240,
   parameter int OPEN_DEPTH  = 16,
   parameter int SPAN_LIMIT  = 256
) (
   input logic     clock,
   input logic     reset,
   soc_req_if.sink req_chan,
   soc_rsp_if.source rsp_chan
);
   localparam int AW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
   localparam int CW = $clog2(OPEN_DEPTH + 1);
   localparam int SW = $clog2(SPAN_LIMIT + 1);
   localparam logic [8:0] ROWS = 9'(COLUMN_ROWS);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_READ  = 8'b00000100,
      ST_EVAL  = 8'b00001000,
      ST_SHRD  = 8'b00010000,
      ST_SHWR  = 8'b00100000,
      ST_OUT   = 8'b01000000,
      ST_FIN   = 8'b10000000
   } state_type;

   state_type     state_ff, state_in;
   req_type_type  req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] spans_ff, spans_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic          shup_ff, shup_in;
   logic [8:0]    a_ff, a_in, b_ff, b_in;
   logic [8:0]    top_ff, top_in;
   logic          any_ff, any_in;
   rsp_type       held_ff, held_in;
   logic          heldv_ff, heldv_in;
   range_type     hold_ff, hold_in;
   range_type     first_ff, first_in, lastr_ff, lastr_in;
   logic          fast_ff, fast_in;
   logic          ovalid_ff, ovalid_in;
   rsp_type       out_ff, out_in;
   logic [8:0]    y0_ff, y0_in, y1_ff, y1_in;
   logic          pend_ff, pend_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   range_type     wr_data, rd_data;
   logic [15:0]   vst;

   soc_ram #(.WIDTH(18), .DEPTH(OPEN_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   soc_tex u_tex (.row(y0_ff), .face_top(req_ff.face_top_fixed),
      .v_step(req_ff.v_step), .v_start(vst));

   assign req_chan.ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_chan.valid = ovalid_ff;
   assign rsp_chan.data  = out_ff;

   // clamped candidate range from the port
   logic signed [15:0] ca, cb;
   always_comb begin
      ca = (req_chan.data.row_start < 0) ? 16'sd0 : req_chan.data.row_start;
      cb = (req_chan.data.row_end > $signed({7'd0, ROWS})) ? $signed({7'd0, ROWS})
           : req_chan.data.row_end;
   end

   logic [8:0] c0, c1;
   always_comb begin
      c0 = (a_ff > rd_data.lo) ? a_ff : rd_data.lo;
      c1 = (b_ff < rd_data.hi) ? b_ff : rd_data.hi;
   end

   always_comb begin
      state_in = state_ff; req_in = req_ff; cnt_in = cnt_ff; spans_in = spans_ff;
      idx_in = idx_ff; sh_in = sh_ff; shup_in = shup_ff; a_in = a_ff; b_in = b_ff;
      top_in = top_ff; any_in = any_ff; held_in = held_ff; heldv_in = heldv_ff;
      hold_in = hold_ff;
      first_in = first_ff; lastr_in = lastr_ff; fast_in = fast_ff;
      ovalid_in = ovalid_ff; out_in = out_ff; y0_in = y0_ff; y1_in = y1_ff;
      pend_in = pend_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = idx_ff[AW-1:0];
      if (ovalid_ff && rsp_chan.ready) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
            wr_data = (idx_ff == '0) ? '{lo: 9'd0, hi: ROWS} : '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(OPEN_DEPTH - 1)) begin
               state_in = ST_IDLE; cnt_in = CW'(1); spans_in = '0;
               first_in = '{lo: 9'd0, hi: ROWS}; lastr_in = '{lo: 9'd0, hi: ROWS};
               idx_in = '0;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid && !ovalid_ff) begin
               req_in = req_chan.data;
               top_in = {1'b0, req_chan.data.top_row_in};
               any_in = 1'b0; heldv_in = 1'b0; idx_in = '0;
               a_in = ca[8:0]; b_in = cb[8:0];
               if (req_chan.data.req_type == REQ_COLUMN) begin
                  state_in = ST_CLEAR; idx_in = '0;
                  out_in = '0; out_in.top_row_out = req_chan.data.top_row_in;
                  out_in.last = 1'b1; ovalid_in = 1'b1;
               end else if (ca >= cb || cnt_ff == '0 || cb <= $signed({7'd0, first_ff.lo})
                            || ca >= $signed({7'd0, lastr_ff.hi})) begin
                  out_in = '0; out_in.top_row_out = req_chan.data.top_row_in;
                  out_in.last = 1'b1; ovalid_in = 1'b1;
               end else begin
                  fast_in = (cnt_ff == CW'(1)) && (first_ff.lo == 9'd0)
                            && (cb >= $signed({7'd0, first_ff.hi}));
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // address presented; data arrives next cycle
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (fast_ff) begin
               pend_in = 1'b0;
               if (a_ff < rd_data.hi) begin
                  wr_en = 1'b1; wr_addr = '0; wr_data = '{lo: 9'd0, hi: a_ff};
                  first_in = '{lo: 9'd0, hi: a_ff}; lastr_in = first_in;
                  if (a_ff == 9'd0) cnt_in = '0;
                  if (a_ff < top_ff) top_in = a_ff;
                  any_in = 1'b1;
                  if (spans_ff < SW'(SPAN_LIMIT)) begin
                     spans_in = spans_ff + 1'b1;
                     y0_in = a_ff; y1_in = rd_data.hi; pend_in = 1'b1;
                  end
               end
               state_in = ST_OUT; idx_in = cnt_ff; // marks the walk as done
            end else if (idx_ff >= cnt_ff || idx_ff >= CW'(OPEN_DEPTH)
                         || rd_data.lo >= b_ff) begin
               pend_in = 1'b0; state_in = ST_FIN;
            end else if (c0 >= c1) begin
               idx_in = idx_ff + 1'b1; state_in = ST_READ; pend_in = 1'b0;
            end else begin
               pend_in = 1'b0;
               if (spans_ff < SW'(SPAN_LIMIT)) begin
                  spans_in = spans_ff + 1'b1; any_in = 1'b1;
                  if (c0 < top_in) top_in = c0;
                  y0_in = c0; y1_in = c1; pend_in = 1'b1;
               end
               wr_addr = idx_ff[AW-1:0];
               if (c0 > rd_data.lo && c1 < rd_data.hi) begin
                  if (cnt_ff < CW'(OPEN_DEPTH)) begin
                     wr_en = 1'b1; wr_data = '{lo: rd_data.lo, hi: c0};
                     hold_in = '{lo: c1, hi: rd_data.hi};
                     if (idx_ff == '0) first_in = wr_data;
                     if (idx_ff + 1'b1 == cnt_ff) lastr_in = hold_in;
                     cnt_in = cnt_ff + 1'b1;
                     sh_in = cnt_ff; shup_in = 1'b1; state_in = ST_SHRD;
                  end else begin
                     wr_en = 1'b1;
                     if ((c0 - rd_data.lo) >= (rd_data.hi - c1))
                        wr_data = '{lo: rd_data.lo, hi: c0};
                     else wr_data = '{lo: c1, hi: rd_data.hi};
                     if (idx_ff == '0) first_in = wr_data;
                     if (idx_ff + 1'b1 == cnt_ff) lastr_in = wr_data;
                     idx_in = idx_ff + 1'b1; state_in = ST_OUT;
                  end
               end else if (c0 > rd_data.lo || c1 < rd_data.hi) begin
                  wr_en = 1'b1;
                  wr_data = (c0 > rd_data.lo) ? '{lo: rd_data.lo, hi: c0}
                                              : '{lo: c1, hi: rd_data.hi};
                  if (idx_ff == '0) first_in = wr_data;
                  if (idx_ff + 1'b1 == cnt_ff) lastr_in = wr_data;
                  idx_in = idx_ff + 1'b1; state_in = ST_OUT;
               end else begin
                  // whole range consumed: pull later entries down
                  sh_in = idx_ff; shup_in = 1'b0; cnt_in = cnt_ff - 1'b1;
                  state_in = ST_SHRD;
               end
            end
         end
         ST_SHRD: begin
            if (shup_ff) begin
               if (sh_ff > idx_ff + 1'b1) begin
                  rd_addr = AW'(sh_ff - 1'b1); state_in = ST_SHWR;
               end else begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff + 1'b1); wr_data = hold_ff;
                  idx_in = idx_ff + 2'd2; state_in = ST_OUT;
               end
            end else begin
               if (sh_ff + 1'b1 <= cnt_ff) begin
                  rd_addr = AW'(sh_ff + 1'b1); state_in = ST_SHWR;
               end else begin
                  wr_en = 1'b1; wr_addr = AW'(cnt_ff); wr_data = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SHWR: begin
            wr_en = 1'b1;
            wr_addr = AW'(sh_ff); wr_data = rd_data;
            if (shup_ff) begin
               if (sh_ff == cnt_ff - 1'b1) lastr_in = rd_data;
               sh_in = sh_ff - 1'b1;
            end else begin
               if (sh_ff == '0) first_in = rd_data;
               if (sh_ff + 1'b1 == cnt_ff) lastr_in = rd_data;
               sh_in = sh_ff + 1'b1;
            end
            state_in = ST_SHRD;
         end
         ST_OUT: begin
            if (!pend_ff) begin
               state_in = (fast_ff) ? ST_FIN : ST_READ;
            end else if (!heldv_ff || !ovalid_ff || rsp_chan.ready) begin
               // a span is held back until the next one exists, so the final one can
               // carry the last flag
               if (heldv_ff) begin
                  out_in = held_ff; ovalid_in = 1'b1;
               end
               held_in = '0;
               held_in.span_valid = 1'b1;
               held_in.span_row_start = y0_ff[7:0];
               held_in.span_row_end = y1_ff[7:0];
               held_in.span_depth_q8 = req_ff.depth_q8;
               held_in.span_material = req_ff.material;
               held_in.span_attr_out = req_ff.span_attributes;
               held_in.span_v_step = req_ff.v_step;
               held_in.span_v_start = vst & WRAP16;
               held_in.span_plane_height = req_ff.plane_height;
               heldv_in = 1'b1; pend_in = 1'b0;
               state_in = (fast_ff) ? ST_FIN : ST_READ;
            end
         end
         ST_FIN: begin
            if (!ovalid_ff || rsp_chan.ready) begin
               if (heldv_ff) out_in = held_ff;
               else out_in = '0;
               out_in.last = 1'b1; ovalid_in = 1'b1;
               out_in.painted_any = any_ff; out_in.top_row_out = top_ff[7:0];
               heldv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; idx_ff <= '0; cnt_ff <= CW'(1); spans_ff <= '0;
         ovalid_ff <= 1'b0; pend_ff <= 1'b0; heldv_ff <= 1'b0;
         first_ff <= '{lo: 9'd0, hi: ROWS}; lastr_ff <= '{lo: 9'd0, hi: ROWS};
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; cnt_ff <= cnt_in;
         spans_ff <= spans_in; ovalid_ff <= ovalid_in; pend_ff <= pend_in;
         heldv_ff <= heldv_in;
         first_ff <= first_in; lastr_ff <= lastr_in;
      end
      req_ff <= req_in; sh_ff <= sh_in; shup_ff <= shup_in; a_ff <= a_in; b_ff <= b_in;
      top_ff <= top_in; any_ff <= any_in; held_ff <= held_in; hold_ff <= hold_in;
      fast_ff <= fast_in; out_ff <= out_in; y0_ff <= y0_in; y1_ff <= y1_in;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(OPEN_DEPTH))
      else $error("open count overflow");
   assert property (@(posedge clock) disable iff (reset)
      spans_ff <= SW'(SPAN_LIMIT)) else $error("span count overflow");
   assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !ovalid_ff) else $error("ready with result pending");
   assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_chan.ready) |=> $stable(out_ff)) else $error("result changed");
endmodule

// ----- tb/sv/span_occlusion_clipper_core_tb.sv -----
// Self-checking testbench for the span occlusion clipper core.
`timescale 1ns / 100ps
module span_occlusion_clipper_core_tb import soc_pkg::*; ();

   localparam int COLUMN_ROWS = 240;
   localparam int OPEN_DEPTH  = 16;
   localparam int SPAN_LIMIT  = 256;
   localparam int RANDOM_ITEMS = 345;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DIR_ROWS    = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   soc_req_if req_if ();
   soc_rsp_if rsp_if ();

   span_occlusion_clipper_core #(
      .COLUMN_ROWS(COLUMN_ROWS),
      .OPEN_DEPTH (OPEN_DEPTH),
      .SPAN_LIMIT (SPAN_LIMIT)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: open row ranges of the current column
   int      open_lo [OPEN_DEPTH];
   int      open_hi [OPEN_DEPTH];
   int      open_cnt;
   int      spans_used;
   rsp_type span_q[$];

   int mismatches = 0;
   int items_sent = 0;
   int columns_sent = 0;
   int spans_seen = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic void column_reset();
      for (int k = 0; k < OPEN_DEPTH; k++) begin
         open_lo[k] = 0;
         open_hi[k] = 0;
      end
      open_hi[0] = COLUMN_ROWS;
      open_cnt = 1;
      spans_used = 0;
   endfunction

   function automatic logic [15:0] tex_start(longint row, longint ft, longint step);
      longint d;
      longint p;
      d = row * 256 - ft;
      p = ((d < 0 ? -d : d) * step) >>> 8;
      if (d < 0) p = -p;
      return p[15:0];
   endfunction

   function automatic void push_span(req_type_type r, longint c0, longint c1, longint ft);
      rsp_type s;
      s = '0;
      s.span_valid        = 1'b1;
      s.span_row_start    = c0[7:0];
      s.span_row_end      = c1[7:0];
      s.span_depth_q8     = r.depth_q8;
      s.span_material     = r.material;
      s.span_attr_out     = r.span_attributes;
      s.span_v_step       = r.v_step;
      s.span_v_start      = tex_start(c0, ft, longint'(r.v_step));
      s.span_plane_height = r.plane_height;
      span_q.push_back(s);
   endfunction

   function automatic void clip_paint(req_type_type r);
      longint a, b, ft, top, o0, o1, c0, c1;
      bit     any;
      int     n, i, no;
      rsp_type s;
      a   = longint'($signed(r.row_start));
      b   = longint'($signed(r.row_end));
      ft  = longint'($signed(r.face_top_fixed));
      top = longint'(r.top_row_in);
      any = 1'b0;
      n   = 0;
      if (r.req_type == REQ_COLUMN) begin
         column_reset();
      end else begin
         no = open_cnt;
         if (a < 0) a = 0;
         if (b > COLUMN_ROWS) b = COLUMN_ROWS;
         if (a < b && no != 0 && b > open_lo[0] && a < open_hi[no-1]) begin
            if (no == 1 && open_lo[0] == 0 && b >= open_hi[0]) begin
               // single range from row 0: shrink it to [0, a)
               b = open_hi[0];
               if (a < b) begin
                  if (spans_used < SPAN_LIMIT) begin
                     spans_used++;
                     push_span(r, a, b, ft);
                     n = 1;
                  end
                  open_hi[0] = int'(a);
                  if (a <= 0) open_cnt = 0;
                  if (a < top) top = a;
                  any = 1'b1;
               end
            end else begin
               i = 0;
               while (i < open_cnt && i < OPEN_DEPTH) begin
                  o0 = open_lo[i];
                  o1 = open_hi[i];
                  if (o0 >= b) break;
                  c0 = a > o0 ? a : o0;
                  c1 = b < o1 ? b : o1;
                  if (c0 >= c1) begin
                     i++;
                     continue;
                  end
                  if (spans_used < SPAN_LIMIT) begin
                     spans_used++;
                     push_span(r, c0, c1, ft);
                     n++;
                     any = 1'b1;
                     if (c0 < top) top = c0;
                  end
                  if (c0 > o0 && c1 < o1) begin
                     if (open_cnt < OPEN_DEPTH) begin
                        for (int j = open_cnt; j > i + 1; j--) begin
                           open_lo[j] = open_lo[j-1];
                           open_hi[j] = open_hi[j-1];
                        end
                        open_hi[i]   = int'(c0);
                        open_lo[i+1] = int'(c1);
                        open_hi[i+1] = int'(o1);
                        open_cnt++;
                        i += 2;
                     end else begin
                        // list full: keep the larger piece, lower one on a tie
                        if (c0 - o0 >= o1 - c1) open_hi[i] = int'(c0);
                        else open_lo[i] = int'(c1);
                        i++;
                     end
                  end else if (c0 > o0) begin
                     open_hi[i] = int'(c0);
                     i++;
                  end else if (c1 < o1) begin
                     open_lo[i] = int'(c1);
                     i++;
                  end else begin
                     for (int j = i; j + 1 < open_cnt; j++) begin
                        open_lo[j] = open_lo[j+1];
                        open_hi[j] = open_hi[j+1];
                     end
                     open_lo[open_cnt-1] = 0;
                     open_hi[open_cnt-1] = 0;
                     open_cnt--;
                  end
               end
            end
         end
      end
      if (n == 0) begin
         s = '0;
         span_q.push_back(s);
      end
      s = span_q[$];
      s.painted_any = any;
      s.top_row_out = top[7:0];
      s.last        = 1'b1;
      span_q[$] = s;
   endfunction

   function automatic req_type_type make_req(req_kind_type kind, int a, int b, int ft,
                                             logic [15:0] step, logic [7:0] top);
      req_type_type r;
      r.req_type        = kind;
      r.row_start       = a[15:0];
      r.row_end         = b[15:0];
      r.face_top_fixed  = ft[23:0];
      r.v_step          = step;
      r.plane_height    = 8'($urandom);
      r.depth_q8        = 16'($urandom);
      r.material        = 8'($urandom);
      r.span_attributes = 28'($urandom);
      r.top_row_in      = top;
      return r;
   endfunction

   function automatic req_type_type random_req();
      req_type_type r;
      int a, w, mode;
      mode = $urandom_range(9);
      a = $urandom_range(239);
      w = $urandom_range(1, 16);
      if (mode == 0) begin
         a = int'($signed(16'($urandom)));
         w = int'($signed(16'($urandom))) - a;
      end else if (mode <= 2) begin
         a = $urandom_range(260) - 10;
         w = $urandom_range(250);
      end
      r = make_req($urandom_range(24) == 0 ? REQ_COLUMN : REQ_PAINT, a, a + w,
                   ($urandom_range(3) == 0) ? int'($urandom)
                                            : a * 256 - int'($urandom_range(8191)),
                   16'($urandom), 8'($urandom_range(240)));
      return r;
   endfunction

   // drive one item and record its expected results at acceptance
   task automatic send_item(req_type_type r, bit typed);
      rsp_type t;
      int      base;
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      base = span_q.size();
      clip_paint(r);
      if (typed) begin
         // nothing painted here: one empty result, top row passed through
         while (span_q.size() > base) void'(span_q.pop_back());
         t = '0;
         t.top_row_out = r.top_row_in;
         t.last        = 1'b1;
         span_q.push_back(t);
      end
      items_sent++;
      if (r.req_type == REQ_COLUMN) columns_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // result checking and response-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (span_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item %p", rsp_if.data);
            end else begin
               if (rsp_if.data !== span_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", span_q[0], rsp_if.data);
               end
               if (span_q[0].span_valid) spans_seen++;
               void'(span_q.pop_front());
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   req_type_type dir_item [DIR_ROWS];
   bit           dir_typed[DIR_ROWS];

   initial begin
      int k;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      column_reset();
      k = 0;
      dir_item[k] = make_req(REQ_COLUMN, 0, 0, 0, 16'h0000, 8'd240); dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_PAINT, 0, 240, 0, 16'h1000, 8'd240); k++;
      dir_item[k] = make_req(REQ_COLUMN, 0, 0, 0, 16'h0, 8'd0); dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_PAINT, -30000, 30000, -7680000, 16'hFFFF, 8'd200); k++;
      dir_item[k] = make_req(REQ_PAINT, 10, 20, 0, 16'h1000, 8'd77); dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_COLUMN, 0, 0, 0, 16'h0, 8'd128); dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_PAINT, 100, 100, 0, 16'h1000, 8'd128);
      dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_PAINT, 30000, 30000, 0, 16'h1000, 8'd99);
      dir_typed[k] = 1; k++;
      dir_item[k] = make_req(REQ_PAINT, 100, 140, 7680000, 16'hFFFF, 8'd240); k++;
      dir_item[k] = make_req(REQ_PAINT, 90, 110, -7680000, 16'h8001, 8'd240); k++;
      dir_item[k] = make_req(REQ_PAINT, 200, 30000, 51200, 16'h0000, 8'd240); k++;
      dir_item[k] = make_req(REQ_PAINT, -5, 5, -256, 16'h1000, 8'd3); k++;
      dir_item[k] = make_req(REQ_COLUMN, 0, 0, 0, 16'h0, 8'd255); dir_typed[k] = 1; k++;
      // single-row holes fill the open list, the last one hits a full list
      for (int h = 1; h <= 16; h++) begin
         dir_item[k] = make_req(REQ_PAINT, 3 * h + 7 * (h / 15), 3 * h + 1 + 7 * (h / 15),
                                int'($urandom), 16'($urandom), 8'd240);
         k++;
      end
      dir_item[k] = make_req(REQ_PAINT, 0, 240, 0, 16'h1000, 8'd240); k++;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 12;
      recv_stall_pct = 58;
      for (int d = 0; d < DIR_ROWS; d++) send_item(dir_item[d], dir_typed[d]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 58;
            recv_stall_pct = 12;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         send_item(random_req(), 1'b0);
      end
      req_if.valid <= 1'b0;
      while (span_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Covered %0d items (%0d column starts), %0d spans checked.",
               items_sent, columns_sent, spans_seen);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0 && span_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
